@@ rtl/scdt_pkg.sv @@
// shared constants, types and tables for the seconds to civil datetime core
`timescale 1ns / 1ps

package scdt_pkg;

    // pipeline shape
    localparam int PIPE_DEPTH = 12;

    // supported input span, 0001-01-01T00:00:00 to 9999-12-31T23:59:59
    localparam logic signed [39:0] SEC_MIN  = -40'sd62135596800;
    localparam logic signed [39:0] SEC_SPAN = 40'sd315537897599;

    localparam logic [16:0] DAY_SECS      = 17'd86400;
    localparam logic [5:0]  MIN_SECS      = 6'd60;
    localparam logic [17:0] ERA_DAYS      = 18'd146097;
    localparam logic [17:0] ERA_LAST_DOE  = 18'd146096;
    localparam logic [8:0]  YEAR_DAYS     = 9'd365;
    localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
    localparam logic [10:0] YEAR_BASE     = 11'd1900;
    // days from 0000-03-01 to 0001-01-01
    localparam logic [8:0]  MARCH_TO_JAN  = 9'd306;
    localparam logic [3:0]  MP_JANUARY    = 4'd10;

    // reciprocals, ceil(2^k / d) with k = width of dividend + ceil(log2 d)
    localparam logic [32:0] M_675   = 33'(((64'd1 << 42) + 64'd674) / 64'd675);
    localparam logic [22:0] M_ERA   = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    localparam logic [17:0] M_60S   = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
    localparam logic [11:0] M_60T   = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
    localparam logic [18:0] M_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  M_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] M_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    // first day of year of each march-based month, (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/seconds_to_civil_datetime_core.sv @@
// epoch seconds to proleptic gregorian date and time, twelve stage pipeline
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------------
//  input   | in_valid  | in_stall  | epoch_seconds
//  output  | out_valid | out_stall | year_since_1900, month_index, day_of_month,
//          |           |           | hour_of_day, minute_of_hour,
//          |           |           | second_of_minute, out_of_range
//
//  one transfer per cycle in and out while out_stall is low; the deepest
//  register stage holds one reciprocal multiply of about 32x33 bits (the
//  split of the seconds into days)
//  rst_n clears only the stage valid bits; data registers are not reset
//  each stage moves when it is empty or the stage after it moves, so bubbles
//  close up under out_stall and input is taken until every stage is full
`timescale 1ns / 1ps

module seconds_to_civil_datetime_core
    import scdt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [38:0] epoch_seconds,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [13:0] year_since_1900,
    output logic [3:0]         month_index,
    output logic [4:0]         day_of_month,
    output logic [4:0]         hour_of_day,
    output logic [5:0]         minute_of_hour,
    output logic [5:0]         second_of_minute,
    output logic               out_of_range
);

    // ------------------------------------------------------------------
    // stage handshake
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] adv;

    assign adv[PIPE_DEPTH-1] = !v_reg[PIPE_DEPTH-1] || !out_stall;

    genvar g;
    generate
        for (g = 0; g < PIPE_DEPTH - 1; g++)
        begin : g_adv
            assign adv[g] = !v_reg[g] || adv[g+1];
        end
    endgenerate

    // valid bits follow their data, each stage only when it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = v_reg[PIPE_DEPTH-1];

    // ------------------------------------------------------------------
    // stage 0: range check, offset to seconds since 0001-01-01
    // ------------------------------------------------------------------
    logic signed [39:0] off_s;
    logic               oor_next;
    logic               oor0_reg;
    logic [38:0]        u0_reg;

    assign off_s    = {epoch_seconds[38], epoch_seconds} - SEC_MIN;
    assign oor_next = off_s[39] || (off_s > SEC_SPAN);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            oor0_reg <= oor_next;
            u0_reg   <= off_s[38:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: day number, (u >> 7) / 675 by reciprocal
    // ------------------------------------------------------------------
    logic [64:0] day_prod;
    logic        oor1_reg;
    logic [21:0] d1_reg;
    logic [16:0] ulo1_reg;

    assign day_prod = 65'(u0_reg[38:7]) * 65'(M_675);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            oor1_reg <= oor0_reg;
            d1_reg   <= day_prod[63:42];
            ulo1_reg <= u0_reg[16:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: second of day, day count from 0000-03-01
    // ------------------------------------------------------------------
    logic [38:0] day_back;
    logic        oor2_reg;
    logic [16:0] sod2_reg;
    logic [21:0] aday2_reg;

    assign day_back = 39'(d1_reg) * 39'(DAY_SECS);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            oor2_reg  <= oor1_reg;
            sod2_reg  <= ulo1_reg - day_back[16:0];
            aday2_reg <= d1_reg + 22'(MARCH_TO_JAN);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: era and minute of day
    // ------------------------------------------------------------------
    logic [44:0] era_prod;
    logic [34:0] tmin_prod;
    logic        oor3_reg;
    logic [4:0]  era3_reg;
    logic [21:0] aday3_reg;
    logic [10:0] t3_reg;
    logic [16:0] sod3_reg;

    assign era_prod  = 45'(aday2_reg) * 45'(M_ERA);
    assign tmin_prod = 35'(sod2_reg) * 35'(M_60S);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            oor3_reg  <= oor2_reg;
            era3_reg  <= era_prod[44:40];
            aday3_reg <= aday2_reg;
            t3_reg    <= tmin_prod[33:23];
            sod3_reg  <= sod2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: day of era, second and hour
    // ------------------------------------------------------------------
    logic [21:0] era_back;
    logic [21:0] doe_full;
    logic [16:0] sec_back;
    logic [16:0] sec_full;
    logic [22:0] hour_prod;
    logic        oor4_reg;
    logic [17:0] doe4_reg;
    logic [4:0]  era4_reg;
    logic [10:0] t4_reg;
    logic [5:0]  sec4_reg;
    logic [4:0]  hour4_reg;

    assign era_back  = 22'(era3_reg) * 22'(ERA_DAYS);
    assign doe_full  = aday3_reg - era_back;
    assign sec_back  = 17'(t3_reg) * 17'(MIN_SECS);
    assign sec_full  = sod3_reg - sec_back;
    assign hour_prod = 23'(t3_reg) * 23'(M_60T);

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            oor4_reg  <= oor3_reg;
            doe4_reg  <= doe_full[17:0];
            era4_reg  <= era3_reg;
            t4_reg    <= t3_reg;
            sec4_reg  <= sec_full[5:0];
            hour4_reg <= hour_prod[21:17];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: leap-corrected day of era, minute
    // ------------------------------------------------------------------
    logic [36:0] q1460_prod;
    logic [36:0] q36524_prod;
    logic        last_doe;
    logic [17:0] x_next;
    logic [10:0] min_back;
    logic [10:0] min_full;
    logic        oor5_reg;
    logic [17:0] x5_reg;
    logic [17:0] doe5_reg;
    logic [4:0]  era5_reg;
    hms_t        hms5_reg;

    assign q1460_prod  = 37'(doe4_reg) * 37'(M_1460);
    assign q36524_prod = 37'(doe4_reg) * 37'(M_36524);
    assign last_doe    = (doe4_reg == ERA_LAST_DOE);
    assign x_next      = doe4_reg - 18'(q1460_prod[36:29]) + 18'(q36524_prod[36:34])
                         - 18'(last_doe);
    assign min_back    = 11'(hour4_reg) * 11'(MIN_SECS);
    assign min_full    = t4_reg - min_back;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            oor5_reg        <= oor4_reg;
            x5_reg          <= x_next;
            doe5_reg        <= doe4_reg;
            era5_reg        <= era4_reg;
            hms5_reg.hour   <= hour4_reg;
            hms5_reg.minute <= min_full[5:0];
            hms5_reg.second <= sec4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: year of era
    // ------------------------------------------------------------------
    logic [36:0] yoe_prod;
    logic        oor6_reg;
    logic [8:0]  yoe6_reg;
    logic [17:0] doe6_reg;
    logic [4:0]  era6_reg;
    hms_t        hms6_reg;

    assign yoe_prod = 37'(x5_reg) * 37'(M_365);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            oor6_reg <= oor5_reg;
            yoe6_reg <= yoe_prod[35:27];
            doe6_reg <= doe5_reg;
            era6_reg <= era5_reg;
            hms6_reg <= hms5_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: century count within the era
    // ------------------------------------------------------------------
    logic [18:0] q100_prod;
    logic        oor7_reg;
    logic [2:0]  q100_7_reg;
    logic [8:0]  yoe7_reg;
    logic [17:0] doe7_reg;
    logic [4:0]  era7_reg;
    hms_t        hms7_reg;

    assign q100_prod = 19'(yoe6_reg) * 19'(M_100);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            oor7_reg   <= oor6_reg;
            q100_7_reg <= q100_prod[18:16];
            yoe7_reg   <= yoe6_reg;
            doe7_reg   <= doe6_reg;
            era7_reg   <= era6_reg;
            hms7_reg   <= hms6_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: day of year, march based
    // ------------------------------------------------------------------
    logic [17:0] year_days;
    logic [17:0] doy_full;
    logic        oor8_reg;
    logic [8:0]  doy8_reg;
    logic [8:0]  yoe8_reg;
    logic [4:0]  era8_reg;
    hms_t        hms8_reg;

    assign year_days = 18'(yoe7_reg) * 18'(YEAR_DAYS) + 18'(yoe7_reg[8:2])
                       - 18'(q100_7_reg);
    assign doy_full  = doe7_reg - year_days;

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            oor8_reg <= oor7_reg;
            doy8_reg <= doy_full[8:0];
            yoe8_reg <= yoe7_reg;
            era8_reg <= era7_reg;
            hms8_reg <= hms7_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: month numerator 5 * doy + 2
    // ------------------------------------------------------------------
    logic        oor9_reg;
    logic [10:0] v9_reg;
    logic [8:0]  doy9_reg;
    logic [8:0]  yoe9_reg;
    logic [4:0]  era9_reg;
    hms_t        hms9_reg;

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            oor9_reg <= oor8_reg;
            v9_reg   <= 11'(doy8_reg) * 11'd5 + 11'd2;
            doy9_reg <= doy8_reg;
            yoe9_reg <= yoe8_reg;
            era9_reg <= era8_reg;
            hms9_reg <= hms8_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: march based month, divide by 153
    // ------------------------------------------------------------------
    logic [22:0] mp_prod;
    logic        oor10_reg;
    logic [3:0]  mp10_reg;
    logic [8:0]  doy10_reg;
    logic [8:0]  yoe10_reg;
    logic [4:0]  era10_reg;
    hms_t        hms10_reg;

    assign mp_prod = 23'(v9_reg) * 23'(M_153);

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            oor10_reg <= oor9_reg;
            mp10_reg  <= mp_prod[22:19];
            doy10_reg <= doy9_reg;
            yoe10_reg <= yoe9_reg;
            era10_reg <= era9_reg;
            hms10_reg <= hms9_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 11: output register, calendar fields or zeros when out of range
    // ------------------------------------------------------------------
    logic        jan_feb;
    logic [8:0]  dom_full;
    logic [3:0]  month_next;
    logic [13:0] year_next;
    logic signed [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    hms_t        hms_reg;
    logic        oor_reg;

    // january and february belong to the next civil year
    assign jan_feb    = (mp10_reg >= MP_JANUARY);
    assign dom_full   = doy10_reg - month_start(mp10_reg) + 9'd1;
    assign month_next = jan_feb ? (mp10_reg - MP_JANUARY) : (mp10_reg + 4'd2);
    assign year_next  = 14'(era10_reg) * 14'(YEARS_PER_ERA) + 14'(yoe10_reg)
                        + 14'(jan_feb) - 14'(YEAR_BASE);

    always_ff @(posedge clk)
    begin
        if (adv[PIPE_DEPTH-1])
        begin
            oor_reg <= oor10_reg;
            if (oor10_reg)
            begin
                year_reg  <= '0;
                month_reg <= '0;
                day_reg   <= '0;
                hms_reg   <= '0;
            end
            else
            begin
                year_reg  <= $signed(year_next);
                month_reg <= month_next;
                day_reg   <= dom_full[4:0];
                hms_reg   <= hms10_reg;
            end
        end
    end

    assign year_since_1900  = year_reg;
    assign month_index      = month_reg;
    assign day_of_month     = day_reg;
    assign hour_of_day      = hms_reg.hour;
    assign minute_of_hour   = hms_reg.minute;
    assign second_of_minute = hms_reg.second;
    assign out_of_range     = oor_reg;

`ifndef NO_ASSERTIONS
    // an out-of-range result carries all-zero calendar fields
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (year_since_1900 == 14'sd0 && month_index == 4'd0
            && day_of_month == 5'd0 && hour_of_day == 5'd0 && minute_of_hour == 6'd0
            && second_of_minute == 6'd0))
        else $error("out-of-range result has nonzero fields");

    // an in-range result is a legal date and time
    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_of_range) |-> (month_index <= 4'd11 && day_of_month != 5'd0
            && hour_of_day <= 5'd23 && minute_of_hour <= 6'd59
            && second_of_minute <= 6'd59))
        else $error("in-range result has an illegal field");

    // with every stage full and the output stalled, nothing can enter
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && out_stall) |-> in_stall)
        else $error("input taken while the pipeline is full and stalled");
`endif

endmodule

@@ sim/tb_seconds_to_civil_datetime_core.sv @@
// testbench for seconds_to_civil_datetime_core: directed, backpressure and random timestamps
`timescale 1ns / 1ps

module tb_seconds_to_civil_datetime_core;

    import scdt_pkg::PIPE_DEPTH;

    // supported span, 0001-01-01T00:00:00 .. 9999-12-31T23:59:59
    localparam longint FIRST_SECOND = -64'sd62135596800;
    localparam longint LAST_SECOND  = 64'sd253402300799;
    localparam longint FIRST_DAY    = -64'sd719162;
    localparam longint DAY_COUNT    = 64'sd3652059;
    // extremes of the 39-bit input port
    localparam longint PORT_MIN     = -64'sd274877906944;
    localparam longint PORT_MAX     = 64'sd274877906943;
    // 2000-03-01 as days since the epoch, start of a 400-year cycle
    localparam longint MARCH_2000   = 64'sd11017;
    localparam int     REPORT_LIMIT = 10;
    localparam int     RANDOM_ITEMS = 1750;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    typedef struct packed {
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         mday;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic               out_of_range;
    } civil_t;

    typedef struct {
        logic signed [38:0] secs;
        civil_t             date;
    } pending_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [38:0] epoch_seconds = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [13:0] year_since_1900;
    logic [3:0]         month_index;
    logic [4:0]         day_of_month;
    logic [4:0]         hour_of_day;
    logic [5:0]         minute_of_hour;
    logic [5:0]         second_of_minute;
    logic               out_of_range;

    pending_t    pending_dates[$];
    int          failures = 0;
    int          reports = 0;
    bit          gaps_on = 1'b1;
    int          burst_left = 0;
    bit          hold_req = 1'b0;
    int          hold_len = 0;

    seconds_to_civil_datetime_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .epoch_seconds    (epoch_seconds),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .year_since_1900  (year_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .out_of_range     (out_of_range)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // civil date from epoch seconds, floor split into days, march-based year
    function automatic civil_t civil_from_seconds(input logic signed [38:0] secs);
        civil_t r;
        longint s, day, sod, hr, mn, aday, era, doe, yoe, yr, doy, mp, dd, mon;
        r = '0;
        s = secs;
        if (s < FIRST_SECOND || s > LAST_SECOND)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        // c-style division truncates, so pull negative remainders back up
        day = s / 86400;
        sod = s % 86400;
        if (sod < 0)
        begin
            sod += 86400;
            day -= 1;
        end
        hr = sod / 3600;
        sod -= hr * 3600;
        mn = sod / 60;
        sod -= mn * 60;
        // days since 0000-03-01, split into 400-year cycles
        aday = day + 719468;
        era = (aday >= 0 ? aday : aday - 146096) / 146097;
        doe = aday - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        yr = yoe + era * 400;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        dd = doy - (153 * mp + 2) / 5 + 1;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        // january and february belong to the next civil year
        yr = yr + ((mon <= 2) ? 1 : 0) - 1900;
        r.year = 14'(yr);
        r.month = 4'(mon - 1);
        r.mday = 5'(dd);
        r.hour = 5'(hr);
        r.minute = 6'(mn);
        r.second = 6'(sod);
        return r;
    endfunction

    function automatic longint unsigned rand_u64();
        return {$urandom, $urandom};
    endfunction

    // random timestamp, weighted toward the span, its edges and calendar seams
    function automatic logic signed [38:0] pick_seconds();
        longint unsigned r;
        longint v, day;
        int sel;
        r = rand_u64();
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            v = FIRST_SECOND + longint'(r % 64'(LAST_SECOND - FIRST_SECOND + 1));
        end
        else if (sel < 68)
        begin
            // midnight, last second of the day or noon of a random day
            day = FIRST_DAY + longint'(r % 64'(DAY_COUNT));
            case ($urandom_range(0, 2))
                0:       v = day * 86400;
                1:       v = day * 86400 + 86399;
                default: v = day * 86400 + 43200;
            endcase
        end
        else if (sel < 80)
        begin
            // around late february / march 1 of years that start 4-year blocks,
            // centuries and 400-year cycles
            day = MARCH_2000 + 146097 * ($urandom_range(0, 23) - 4)
                  + 36524 * $urandom_range(0, 3) + 1461 * $urandom_range(0, 24);
            day = day + $urandom_range(0, 3) - 2;
            v = day * 86400 + $urandom_range(0, 86399);
        end
        else if (sel < 88)
        begin
            v = ($urandom_range(0, 1) ? FIRST_SECOND : LAST_SECOND)
                + $urandom_range(0, 2000) - 1000;
        end
        else
        begin
            // raw port value, reaches both far out-of-range ends
            return r[38:0];
        end
        return v[38:0];
    endfunction

    // offer one timestamp and hold it until the transfer happens
    task automatic send_timestamp(input logic signed [38:0] secs);
        pending_t p;
        if (gaps_on && burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        epoch_seconds <= secs;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        p.secs = secs;
        p.date = civil_from_seconds(secs);
        pending_dates.push_back(p);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_list(input longint picks[]);
        foreach (picks[i])
            send_timestamp(picks[i][38:0]);
    endtask

    task automatic test_range_limits();
        send_list('{FIRST_SECOND - 1, FIRST_SECOND, LAST_SECOND, LAST_SECOND + 1,
                    PORT_MIN, PORT_MAX, 0, -1});
    endtask

    task automatic test_day_split();
        // negative seconds must floor into the previous day
        send_list('{86399, 86400, -86400, -86401, -43201, 2147483647, 64'sd2147483648});
    endtask

    task automatic test_leap_rules();
        send_list('{951782400,              // 2000-02-29, leap in a 400-year
                    951868799,              // 2000-02-29 23:59:59
                    -64'sd2203891201,       // 1900-02-28 23:59:59, century not leap
                    -64'sd2203891200,       // 1900-03-01
                    64'sd4107542399,        // 2100-02-28 23:59:59
                    -64'sd11670998400,      // 1600-02-29
                    1735689599,             // 2024-12-31 23:59:59
                    68169600});             // 1972-02-29
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_len = 300;
        hold_req = 1'b1;
        repeat (60) send_timestamp(pick_seconds());
        gaps_on = 1'b1;
    endtask

    task automatic test_random_stream();
        int flip_at;
        flip_at = $urandom_range(100, 300);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // alternate between bursty input and back-to-back stretches
            if (n == flip_at)
            begin
                gaps_on = ~gaps_on;
                flip_at = n + $urandom_range(100, 300);
            end
            send_timestamp(pick_seconds());
        end
    endtask

    // receiver stall pattern, changes mode over random stretches
    initial
    begin
        stall_mode_t mode;
        int mode_left;
        int hold_left;
        int phase;
        mode = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                phase++;
                case (mode)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
                    STALL_PERIODIC: out_stall <= (phase % 4 == 3);
                    default:        out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    // result checker, compares each transfer with the oldest expected date
    always @(posedge clk)
    begin
        civil_t got;
        pending_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{year_since_1900, month_index, day_of_month, hour_of_day,
                    minute_of_hour, second_of_minute, out_of_range};
            if (pending_dates.size() == 0)
            begin
                failures++;
                if (reports < REPORT_LIMIT)
                begin
                    reports++;
                    $display("unexpected result transfer at %0t", $realtime);
                end
            end
            else
            begin
                want = pending_dates.pop_front();
                if (got.year !== want.date.year || got.month !== want.date.month
                    || got.mday !== want.date.mday || got.hour !== want.date.hour
                    || got.minute !== want.date.minute || got.second !== want.date.second
                    || got.out_of_range !== want.date.out_of_range)
                begin
                    failures++;
                    if (reports < REPORT_LIMIT)
                    begin
                        reports++;
                        $display("mismatch for %0d s: expected y%0d m%0d d%0d %0d:%0d:%0d oor %b",
                                 want.secs, want.date.year, want.date.month,
                                 want.date.mday, want.date.hour, want.date.minute,
                                 want.date.second, want.date.out_of_range);
                        $display("    got y%0d m%0d d%0d %0d:%0d:%0d oor %b",
                                 got.year, got.month, got.mday, got.hour,
                                 got.minute, got.second, got.out_of_range);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_range_limits();
        test_day_split();
        test_leap_rules();
        test_backpressure();
        test_random_stream();
        @(negedge clk);
        in_valid <= 1'b0;
        // drain, then give the pipeline time to show any extra transfers
        while (pending_dates.size() > 0) @(posedge clk);
        repeat (4 * PIPE_DEPTH) @(posedge clk);
        if (failures == 0 && pending_dates.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ seconds_to_civil_datetime_core.f @@
rtl/scdt_pkg.sv
rtl/seconds_to_civil_datetime_core.sv
sim/tb_seconds_to_civil_datetime_core.sv
